// ----- hw/rtl/hjbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hjbd_pkg: headset jack button detector package
// Payload types, key and comparator codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package hjbd_pkg;

    // button ADC: 15-bit sample, full scale 1800 mV
    localparam int unsigned ADC_BITS      = 15;
    localparam int unsigned MV_BITS       = 11;
    localparam int unsigned MV_FULL_SCALE = 1800;
    localparam int unsigned PROD_BITS     = ADC_BITS + MV_BITS;

    // threshold reset values, mV, exclusive upper bounds
    localparam logic [MV_BITS-1:0] PLAYPAUSE_MAX_RST = MV_BITS'(90);
    localparam logic [MV_BITS-1:0] VOLUP_MAX_RST     = MV_BITS'(240);
    localparam logic [MV_BITS-1:0] VOLDOWN_MAX_RST   = MV_BITS'(500);

    // configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLAYPAUSE_MAX = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VOLUP_MAX     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VOLDOWN_MAX   = 2'd2;

    // event kinds
    localparam logic MODE_JACK = 1'b0;
    localparam logic MODE_CMP  = 1'b1;

    // comparator states
    localparam logic [1:0] AB_HOOK = 2'd0;
    localparam logic [1:0] AB_MIC  = 2'd1;

    typedef enum logic [1:0] {
        KEY_NONE  = 2'd0,
        KEY_PLAY  = 2'd1,
        KEY_VUP   = 2'd2,
        KEY_VDOWN = 2'd3
    } t_key;

    typedef struct packed {
        logic               mode;
        logic               jack_inserted;
        logic [1:0]         comparator_ab;
        logic               adc_ready;
        logic [ADC_BITS-1:0] adc_raw;
    } t_evt;

    typedef struct packed {
        logic               headphone_in;
        logic               mic_in;
        logic [1:0]         held_key;
        logic               inserted_event;
        logic               removed_event;
        logic [1:0]         pressed_key;
        logic [1:0]         released_key;
        logic [MV_BITS-1:0] key_mv;
    } t_res;

    // button thresholds as programmed
    typedef struct packed {
        logic [MV_BITS-1:0] playpause_max_mv;
        logic [MV_BITS-1:0] volup_max_mv;
        logic [MV_BITS-1:0] voldown_max_mv;
    } t_thr;

    // classifier verdict for one sample
    typedef struct packed {
        t_key               key;
        logic [MV_BITS-1:0] mv;
    } t_cls;

endpackage

// ----- hw/rtl/hjbd_if.sv -----
// ----------------------------------------------------------------------------
// hjbd_if: stream interfaces of the headset jack button detector
// Valid/ready channels for input events and result items.
// ----------------------------------------------------------------------------
interface hjbd_evt_if;
    import hjbd_pkg::*;

    logic valid;
    logic ready;
    t_evt data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hjbd_res_if;
    import hjbd_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/hjbd_classify.sv -----
// ----------------------------------------------------------------------------
// hjbd_classify: button voltage scaling and key decode
// Scales the raw sample to mV and picks the key from the three thresholds.
// ----------------------------------------------------------------------------
module hjbd_classify (
    input  logic                              i_adc_ready,
    input  logic [hjbd_pkg::ADC_BITS-1:0]     i_adc_raw,
    input  hjbd_pkg::t_thr                    i_thr,
    output hjbd_pkg::t_cls                    o_cls
);
    import hjbd_pkg::*;

    logic [PROD_BITS-1:0] prod;
    logic [MV_BITS-1:0]   mv;

    // mv = raw * 1800 / 32768, the divide is a shift
    assign prod = PROD_BITS'(i_adc_raw) * PROD_BITS'(MV_FULL_SCALE);
    assign mv   = prod[PROD_BITS-1:ADC_BITS];

    always_comb begin
        o_cls.mv  = '0;
        o_cls.key = KEY_PLAY;           // timed-out ADC counts as play/pause
        if (i_adc_ready) begin
            o_cls.mv = mv;
            if (mv < i_thr.playpause_max_mv) begin
                o_cls.key = KEY_PLAY;
            end else if (mv < i_thr.volup_max_mv) begin
                o_cls.key = KEY_VUP;
            end else if (mv < i_thr.voldown_max_mv) begin
                o_cls.key = KEY_VDOWN;
            end else begin
                o_cls.key = KEY_NONE;
            end
        end
    end

endmodule

// ----- hw/rtl/hjbd_tracker.sv -----
// ----------------------------------------------------------------------------
// hjbd_tracker: jack and key state tracking
// Holds plug, mic and held-key state and builds the result of one event.
// ----------------------------------------------------------------------------
module hjbd_tracker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  hjbd_pkg::t_evt  i_evt,
    input  hjbd_pkg::t_cls  i_cls,
    output hjbd_pkg::t_res  o_res
);
    import hjbd_pkg::*;

    logic r_plug, n_plug;
    logic r_mic,  n_mic;
    t_key r_key,  n_key;

    logic               ins_ev, rem_ev;
    t_key               pressed, released;
    logic [MV_BITS-1:0] mv_out;

    always_comb begin
        n_plug   = r_plug;
        n_mic    = r_mic;
        n_key    = r_key;
        ins_ev   = 1'b0;
        rem_ev   = 1'b0;
        pressed  = KEY_NONE;
        released = KEY_NONE;
        mv_out   = '0;
        unique case (i_evt.mode)
            MODE_JACK: begin
                if (i_evt.jack_inserted && !r_plug) begin
                    n_plug = 1'b1;
                    n_mic  = (i_evt.comparator_ab == AB_MIC);
                    ins_ev = 1'b1;
                end else if (!i_evt.jack_inserted && r_plug) begin
                    n_plug   = 1'b0;
                    n_mic    = 1'b0;
                    released = r_key;
                    n_key    = KEY_NONE;
                    rem_ev   = 1'b1;
                end
            end
            MODE_CMP: begin
                // only a headset with a mic reports buttons
                if (r_plug && r_mic) begin
                    if (i_evt.comparator_ab == AB_HOOK && r_key == KEY_NONE) begin
                        mv_out = i_cls.mv;
                        if (i_cls.key != KEY_NONE) begin
                            n_key   = i_cls.key;
                            pressed = i_cls.key;
                        end
                    end else if (i_evt.comparator_ab == AB_MIC) begin
                        released = r_key;
                        n_key    = KEY_NONE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plug <= 1'b0;
            r_mic  <= 1'b0;
            r_key  <= KEY_NONE;
        end else if (i_adv) begin
            r_plug <= n_plug;
            r_mic  <= n_mic;
            r_key  <= n_key;
        end
    end

    always_comb begin
        o_res.headphone_in   = n_plug;
        o_res.mic_in         = n_mic;
        o_res.held_key       = n_key;
        o_res.inserted_event = ins_ev;
        o_res.removed_event  = rem_ev;
        o_res.pressed_key    = pressed;
        o_res.released_key   = released;
        o_res.key_mv         = mv_out;
    end

endmodule

// ----- hw/rtl/headset_jack_button_detector.sv -----
// ----------------------------------------------------------------------------
// headset_jack_button_detector: headset jack and inline button tracker
// Records plug/mic presence and decodes inline button presses by voltage.
// ----------------------------------------------------------------------------
// Path: input register, then decode and state update into the result register.
// Throughput: one event per cycle while o_res is not stalled; the state update
//   and decode sit in one register-to-register path, so each event sees the
//   state its predecessor left.
// Reset: synchronous active-low; clears plug, mic, held key and both stage
//   valids, and loads the default thresholds (90, 240, 500 mV).
// ----------------------------------------------------------------------------
module headset_jack_button_detector (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [hjbd_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [hjbd_pkg::MV_BITS-1:0]          i_cfg_data,
    // event input and result output channels
    hjbd_evt_if.sink                              i_evt,
    hjbd_res_if.source                            o_res
);
    import hjbd_pkg::*;

    // thresholds
    t_thr r_thr;

    // stage 1: captured event
    logic r_s1_valid;
    t_evt r_s1_data;

    // stage 2: result register
    logic r_out_valid;
    t_res r_out_data;

    logic s2_take;      // result register is free or drains this cycle
    logic s1_adv;       // stage 1 item moves into the result register
    logic in_xfer;      // input transfer this cycle

    t_cls cls;
    t_res res;

    // ------------------------------------------------------------------------
    // Configuration: index beyond the list is dropped
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.playpause_max_mv <= PLAYPAUSE_MAX_RST;
            r_thr.volup_max_mv     <= VOLUP_MAX_RST;
            r_thr.voldown_max_mv   <= VOLDOWN_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PLAYPAUSE_MAX: r_thr.playpause_max_mv <= i_cfg_data;
                CFG_VOLUP_MAX:     r_thr.volup_max_mv     <= i_cfg_data;
                CFG_VOLDOWN_MAX:   r_thr.voldown_max_mv   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Flow control: two-stage pipeline; the stages do not always move together.
    // Stage 1 keeps taking events while a result waits, as long as it is empty.
    // ------------------------------------------------------------------------
    assign s2_take     = !r_out_valid || o_res.ready;
    assign s1_adv      = r_s1_valid && s2_take;
    assign i_evt.ready = !r_s1_valid || s2_take;
    assign in_xfer     = i_evt.valid && i_evt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_s1_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_data <= i_evt.data;
        end
    end

    // ------------------------------------------------------------------------
    // Decode and state update
    // ------------------------------------------------------------------------
    hjbd_classify u_classify (
        .i_adc_ready (r_s1_data.adc_ready),
        .i_adc_raw   (r_s1_data.adc_raw),
        .i_thr       (r_thr),
        .o_cls       (cls)
    );

    // state commits only when the event moves on, so a stall replays nothing
    hjbd_tracker u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (s1_adv),
        .i_evt   (r_s1_data),
        .i_cls   (cls),
        .o_res   (res)
    );

    // ------------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_take) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // a stalled stage 1 item is not dropped
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_take |=> r_s1_valid)
        else $error("stage 1 item lost during stall");

    // a removal leaves nothing plugged and no key held
    a_removed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.removed_event |->
            !r_out_data.headphone_in && !r_out_data.mic_in &&
            (r_out_data.held_key == KEY_NONE))
        else $error("removal left state behind");

    // a newly pressed key is the held key
    a_press_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_data.pressed_key != KEY_NONE) |->
            (r_out_data.held_key == r_out_data.pressed_key) &&
            (r_out_data.released_key == KEY_NONE))
        else $error("pressed key not held");

    // mic is only recorded with a plug present
    a_mic_needs_plug: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.mic_in |-> r_out_data.headphone_in)
        else $error("mic recorded without plug");

    // a stage 1 advance always lands a valid result
    a_adv_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("advanced item did not reach result register");

endmodule
